[rtl/sscf_pkg.sv]
// ----------------------------------------------------------------------------
// sscf_pkg
// shared types, register codes and the byte fold helper for the
// case-folding substring search
// ----------------------------------------------------------------------------
package sscf_pkg;

   // defaults for the top-level parameters
   localparam int MAX_PATTERN_DEF   = 16;
   localparam int POSITION_BITS_DEF = 16;

   // fixed field widths
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 5;
   localparam int PAT_BYTES   = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int MATCH_POS_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_CASE_FOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LOW     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_HIGH    = 2'd3;

   // letter range and the bit that makes a letter lower case
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [BYTE_W-1:0] LOWER_BIT    = 8'h20;

   // settings seen by the datapath, length already clamped
   typedef struct packed {
      logic                             fold;
      logic [LEN_W-1:0]                 len;
      logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
   } cfg_type;

   // fold A-Z to lower case when on
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic on);
      if (on && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
         return b | LOWER_BIT;
      end
      return b;
   endfunction

endpackage

[rtl/sscf_csr.sv]
// ----------------------------------------------------------------------------
// sscf_csr
// configuration registers; presents the pattern length clamped to the
// supported range
// ----------------------------------------------------------------------------
module sscf_csr
   import sscf_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic                  fold_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_high_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff     <= 1'b1;
         len_ff      <= LEN_W'(1);
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CASE_FOLD:  fold_ff     <= csr_wdata[0];
            CSR_PAT_LENGTH: len_ff      <= csr_wdata[LEN_W-1:0];
            CSR_PAT_LOW:    pat_low_ff  <= csr_wdata;
            CSR_PAT_HIGH:   pat_high_ff <= csr_wdata;
         endcase
      end
   end

   // zero length acts as one, too long acts as the window depth
   always_comb begin
      cfg.fold    = fold_ff;
      cfg.pattern = {pat_high_ff, pat_low_ff};
      if (len_ff == '0) begin
         cfg.len = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_PATTERN)) begin
         cfg.len = LEN_W'(MAX_PATTERN);
      end else begin
         cfg.len = len_ff;
      end
   end

endmodule

[rtl/sscf_compare.sv]
// ----------------------------------------------------------------------------
// sscf_compare
// parallel compare of the newest window bytes against the pattern
// ----------------------------------------------------------------------------
module sscf_compare
   import sscf_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  cfg_type                               cfg,
   input  logic [MAX_PATTERN-1:0][BYTE_W-1:0]    window,
   output logic                                  equal
);

   // entry j (age j) must hold pattern byte len-1-j, for entries below len
   always_comb begin
      logic [LEN_W-1:0]  pidx;
      logic [BYTE_W-1:0] pbyte;
      equal = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pidx  = cfg.len - LEN_W'(1) - LEN_W'(j);
         pbyte = fold_byte(cfg.pattern[pidx[LEN_W-2:0]], cfg.fold);
         if ((LEN_W'(j) < cfg.len) && (window[j] != pbyte)) begin
            equal = 1'b0;
         end
      end
   end

endmodule

[rtl/substring_search_case_fold.sv]
// ----------------------------------------------------------------------------
// substring_search_case_fold
// streaming first-occurrence search for a pattern of 1 to 16 bytes with
// optional A-Z case folding
// ----------------------------------------------------------------------------
// usage:
//  - req carries one text byte per word in tdata, tlast marks the last byte
//    of a string; rsp gives at most one word per string: tuser is found,
//    tdata the start offset of the first match (zero when not found)
//  - a match is reported on the byte that completes it; later bytes of the
//    same string give nothing, and a string that ends unmatched gives a
//    not-found word on its last byte
//  - an accepted byte lands in the input register; its result word loads into
//    the result register once that register is free or being emptied
//  - throughput: one byte per cycle while rsp is not stalled; the shift, fold
//    and parallel compare sit in one stage between the two registers
//  - while rsp is stalled one more byte is still taken into the input
//    register, then req_tready drops until the result word is taken
//  - reset clears the window, the offset counter and the match flag, and
//    loads the registers: folding on, length 1, pattern all zeros
//  - csr writes are taken any cycle but are meant for an idle block
//  - the offset counter stops at its top value; bytes arriving then are
//    neither stored nor matched, their tlast still ends the string
// ----------------------------------------------------------------------------
module substring_search_case_fold
   import sscf_pkg::*;
#(
   parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // text input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] text_byte
   input  logic                   req_tlast,   // end_of_text
   // search result
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [MATCH_POS_W-1:0] rsp_tdata,   // [15:0] match_position
   output logic                   rsp_tuser,   // [0] found
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;

   logic                              s1_valid_ff;
   logic [BYTE_W-1:0]                 s1_byte_ff;
   logic                              s1_last_ff;

   logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_ff;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_in;
   logic [POSITION_BITS-1:0]           seen_ff;
   logic [POSITION_BITS-1:0]           seen_in;
   logic                               matched_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [MATCH_POS_W-1:0]   rsp_pos_ff;

   logic                     advance;
   logic                     store;
   logic                     equal;
   logic                     hit;
   logic                     miss_end;
   logic [POSITION_BITS-1:0] start_pos;

   sscf_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // the result register is free or being emptied
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // shift the folded byte in, oldest byte drops out
   always_comb begin
      window_in[0] = fold_byte(s1_byte_ff, cfg.fold);
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   sscf_compare #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_compare (
      .cfg    (cfg),
      .window (window_in),
      .equal  (equal)
   );

   // match decision for the byte in the input register
   assign store     = (seen_ff != '1);
   assign seen_in   = seen_ff + POSITION_BITS'(1);
   assign hit       = store && !matched_ff && equal
                      && (seen_in >= POSITION_BITS'(cfg.len));
   assign miss_end  = s1_last_ff && !matched_ff && !hit;
   assign start_pos = seen_in - POSITION_BITS'(cfg.len);

   // per-string state
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         seen_ff    <= '0;
         matched_ff <= 1'b0;
      end else if (s1_valid_ff && advance) begin
         if (s1_last_ff) begin
            window_ff  <= '0;
            seen_ff    <= '0;
            matched_ff <= 1'b0;
         end else if (store) begin
            window_ff  <= window_in;
            seen_ff    <= seen_in;
            matched_ff <= matched_ff || hit;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff && (hit || miss_end);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_found_ff <= hit;
         rsp_pos_ff   <= hit ? MATCH_POS_W'(start_pos) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_pos_ff;

   // a not-found word always carries offset zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("not-found result with nonzero offset");

   // the last byte of a string leaves the per-string state cleared
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance && s1_last_ff |=> seen_ff == '0 && !matched_ff)
      else $error("string state not cleared after last byte");

   // a match can only have been seen after at least one byte
   assert property (@(posedge clock) disable iff (reset)
      matched_ff |-> seen_ff != '0)
      else $error("match flag set with no bytes seen");

   // a new result word needs a byte in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result word without an input byte");

endmodule

[bench/tb_substring_search_case_fold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_search_case_fold
// self-checking bench for the streaming first-occurrence substring search
// ----------------------------------------------------------------------------
// text bytes go in on req, search results come back on rsp and are checked
// against a cycle-free copy of the search kept inside the bench. directed
// tasks cover reset values, case folding, length clamping, a register change
// inside a text and offset saturation; random phases then sweep settings
// with planted, partial and absent patterns under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_substring_search_case_fold;
   import sscf_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int POS_TOP     = (1 << POSITION_BITS_DEF) - 1;
   localparam int SETTLE      = 4;

   typedef struct packed {
      logic                   found;
      logic [MATCH_POS_W-1:0] position;
   } search_report_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [MATCH_POS_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // search state mirrored by the bench
   logic                   cfg_fold;
   logic [LEN_W-1:0]       cfg_len;
   logic [8*PAT_BYTES-1:0] cfg_pattern;
   logic [BYTE_W-1:0]      window [PAT_BYTES];
   int unsigned            bytes_seen;
   logic                   matched;
   search_report_type      match_reports [$];

   // pacing and bookkeeping
   logic                   feed_idles = 1'b0;
   logic                   sink_idles = 1'b0;
   int                     ready_left = 0;
   int                     ready_pick;
   int                     mismatch_count = 0;
   int                     texts_sent = 0;
   int                     bytes_sent = 0;
   int                     reports_seen = 0;
   int                     found_seen = 0;
   int                     phases_run = 0;
   int                     idle_cycles;
   search_report_type      due;
   logic [BYTE_W-1:0]      char_pool [10] = '{8'h61, 8'h62, 8'h41, 8'h42, 8'h7a,
                                               8'h5a, 8'h40, 8'h5b, 8'h60, 8'h7b};

   always #6 clock = ~clock;

   substring_search_case_fold uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // A-Z to lower case when folding is on
   function automatic logic [BYTE_W-1:0] lower_letter(input logic [BYTE_W-1:0] b,
                                                      input logic on);
      if (on && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         return b | LOWER_BIT;
      end
      return b;
   endfunction

   function automatic void clear_text_state();
      for (int k = 0; k < PAT_BYTES; k++) begin
         window[k] = '0;
      end
      bytes_seen = 0;
      matched    = 1'b0;
   endfunction

   // advance the search by one accepted byte, queue any report it causes
   function automatic void search_byte(input logic [BYTE_W-1:0] b, input logic last);
      int unsigned       n;
      logic              hit;
      search_report_type r;
      n = cfg_len;
      if (n < 1) n = 1;
      if (n > MAX_PATTERN_DEF) n = MAX_PATTERN_DEF;
      if (bytes_seen < POS_TOP) begin
         for (int k = PAT_BYTES - 1; k > 0; k--) begin
            window[k] = window[k-1];
         end
         window[0] = lower_letter(b, cfg_fold);
         bytes_seen++;
         if (!matched && bytes_seen >= n) begin
            hit = 1'b1;
            for (int k = 0; k < n; k++) begin
               if (window[n-1-k] != lower_letter(cfg_pattern[8*k +: 8], cfg_fold)) hit = 1'b0;
            end
            if (hit) begin
               matched    = 1'b1;
               r.found    = 1'b1;
               r.position = MATCH_POS_W'(bytes_seen - n);
               match_reports.push_back(r);
            end
         end
      end
      if (last) begin
         if (!matched) begin
            r.found    = 1'b0;
            r.position = '0;
            match_reports.push_back(r);
         end
         clear_text_state();
      end
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int feed_gap();
      int r;
      if (!feed_idles) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // byte drawn to make matches and fold edge cases likely
   function automatic logic [BYTE_W-1:0] text_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return char_pool[$urandom_range(0, 3)];
      if (r == 6) return char_pool[$urandom_range(4, 9)];
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [8*PAT_BYTES-1:0] pack_pattern(input string s);
      logic [8*PAT_BYTES-1:0] p;
      p = '0;
      for (int k = 0; k < s.len() && k < PAT_BYTES; k++) begin
         p[8*k +: 8] = s[k];
      end
      return p;
   endfunction

   // one text word; called and returning right after a falling edge
   task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = feed_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      search_byte(b, last);
      bytes_sent++;
      if (last) texts_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input logic [BYTE_W-1:0] text [$]);
      foreach (text[k]) begin
         send_text_byte(text[k], k == text.size() - 1);
      end
   endtask

   task automatic send_ascii(input string s);
      logic [BYTE_W-1:0] text [$];
      for (int k = 0; k < s.len(); k++) begin
         text.push_back(s[k]);
      end
      send_text(text);
   endtask

   // let every pending report arrive, then the pipeline settle
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (match_reports.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write all four registers back to back; junk in the unused upper bits
   task automatic write_config(input logic fold, input logic [LEN_W-1:0] len,
                               input logic [63:0] lo, input logic [63:0] hi);
      logic [CSR_DATA_W-1:0] w;
      w = {$urandom, $urandom};
      w[0] = fold;
      csr_we    <= 1'b1;
      csr_index <= CSR_CASE_FOLD;
      csr_wdata <= w;
      @(negedge clock);
      w = {$urandom, $urandom};
      w[LEN_W-1:0] = len;
      csr_index <= CSR_PAT_LENGTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_PAT_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_PAT_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we      <= 1'b0;
      cfg_fold    = fold;
      cfg_len     = len;
      cfg_pattern = {hi, lo};
   endtask

   // reset settings: folding on, length 1, pattern of zero bytes
   task automatic test_reset_defaults();
      logic [BYTE_W-1:0] text [$];
      text = {8'h61, 8'h00, 8'h62};
      send_text(text);
      send_ascii("z");
      wait_quiet();
   endtask

   // folded and exact compare, bytes after a match, bytes just outside A-Z
   task automatic test_case_folding();
      write_config(1'b1, 5'd3, pack_pattern("HeY"), 64'h0);
      send_ascii("xhEyzz");
      wait_quiet();
      write_config(1'b0, 5'd3, pack_pattern("HeY"), 64'h0);
      send_ascii("hey");
      send_ascii("xHeY");
      wait_quiet();
      write_config(1'b1, 5'd2, pack_pattern("@["), 64'h0);
      send_ascii("`{");
      send_ascii("@[");
      wait_quiet();
   endtask

   // length 0 acts as 1, lengths above 16 act as 16, text shorter than pattern
   task automatic test_pattern_length();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [8*PAT_BYTES-1:0] p;
      write_config(1'b1, 5'd0, pack_pattern("Q"), 64'h0);
      send_ascii("q");
      wait_quiet();
      lo = 64'hff00_5a41_ff00_7a61;
      hi = 64'h00ff_2040_7f80_01fe;
      p  = {hi, lo};
      write_config(1'b1, 5'd31, lo, hi);
      for (int k = 0; k < PAT_BYTES; k++) begin
         send_text_byte(p[8*k +: 8], k == PAT_BYTES - 1);
      end
      wait_quiet();
      write_config(1'b0, 5'd17, lo, hi);
      for (int k = 0; k < PAT_BYTES - 1; k++) begin
         send_text_byte(p[8*k +: 8], k == PAT_BYTES - 2);
      end
      wait_quiet();
   endtask

   // window keeps the folding its bytes were stored with
   task automatic test_change_mid_text();
      write_config(1'b1, 5'd3, pack_pattern("abc"), 64'h0);
      send_text_byte(8'h41, 1'b0);
      send_text_byte(8'h42, 1'b0);
      wait_quiet();
      write_config(1'b0, 5'd3, pack_pattern("abc"), 64'h0);
      send_text_byte(8'h63, 1'b1);
      wait_quiet();
   endtask

   // match at the top offset, then bytes past the stop point ignored
   task automatic test_position_saturation();
      logic [BYTE_W-1:0] b;
      feed_idles = 1'b0;
      sink_idles = 1'b0;
      write_config(1'b0, 5'd1, 64'h71, 64'h0);
      for (int k = 0; k < POS_TOP - 1; k++) begin
         b = BYTE_W'($urandom_range(0, 255));
         if (b == 8'h71) b = 8'h72;
         send_text_byte(b, 1'b0);
      end
      send_text_byte(8'h71, 1'b0);
      send_text_byte(8'h7a, 1'b1);
      for (int k = 0; k < POS_TOP; k++) begin
         b = BYTE_W'($urandom_range(0, 255));
         if (b == 8'h71) b = 8'h70;
         send_text_byte(b, 1'b0);
      end
      send_text_byte(8'h71, 1'b0);
      send_text_byte(8'h71, 1'b1);
      wait_quiet();
   endtask

   // random settings per phase, texts with planted, partial or no pattern
   task automatic test_random_text(input int budget);
      int                     start_bytes;
      int                     phase_start;
      int                     plen;
      int                     r;
      int                     cut;
      logic                   fold;
      logic [LEN_W-1:0]       len;
      logic [8*PAT_BYTES-1:0] pat;
      logic [BYTE_W-1:0]      c;
      logic [BYTE_W-1:0]      text [$];
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < budget) begin
         wait_quiet();
         fold = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (r < 10) len = 5'd0;
         else if (r < 20) len = LEN_W'($urandom_range(17, 31));
         else if (r < 30) len = 5'd16;
         else len = LEN_W'($urandom_range(1, 6));
         unique case (phases_run)
            0: begin fold = 1'b0; len = 5'd1; end
            1: begin fold = 1'b1; len = 5'd16; end
            2: begin fold = 1'b1; len = 5'd31; end
            default: ;
         endcase
         for (int k = 0; k < PAT_BYTES; k++) begin
            pat[8*k +: 8] = text_char();
         end
         if ($urandom_range(0, 4) == 0) pat[63:0] = {$urandom, $urandom};
         write_config(fold, len, pat[63:0], pat[127:64]);
         plen = (len == 0) ? 1 : (len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len;
         feed_idles  = ($urandom_range(0, 3) != 0);
         sink_idles  = ($urandom_range(0, 3) != 0);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 220 && bytes_sent - start_bytes < budget) begin
            text.delete();
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 10);
            repeat (r) text.push_back(text_char());
            r = $urandom_range(0, 9);
            cut = (r < 6) ? plen : (r < 8 && plen > 1) ? $urandom_range(1, plen - 1) : 0;
            for (int k = 0; k < cut; k++) begin
               c = pat[8*k +: 8];
               if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7a && $urandom_range(0, 2) == 0)
                  c = c ^ 8'h20;
               text.push_back(c);
            end
            repeat ($urandom_range(0, 8)) text.push_back(text_char());
            if (text.size() == 0) text.push_back(text_char());
            send_text(text);
         end
         phases_run++;
      end
      wait_quiet();
   endtask

   // result sink: ready pattern with random stalls when enabled
   always @(negedge clock) begin
      if (ready_left > 0) begin
         ready_left--;
      end else if (!sink_idles) begin
         rsp_tready <= 1'b1;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 65) begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(0, 7);
         end else if (ready_pick < 95) begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(9, 29);
         end
      end
   end

   // compare each result word with the oldest pending report
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (rsp_tuser) found_seen++;
         if (match_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result word, found=%0d position=%0d",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            due = match_reports.pop_front();
            if (rsp_tuser !== due.found) begin
               mismatch_count++;
               $display("%0t: found expected %0d actual %0d", $time, due.found, rsp_tuser);
            end
            if (rsp_tdata !== due.position) begin
               mismatch_count++;
               $display("%0t: position expected %0d actual %0d",
                        $time, due.position, rsp_tdata);
            end
         end
      end
   end

   // watchdog: too long without any accepted word
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no progress for %0d cycles, %0d reports pending",
               $time, STALL_LIMIT, match_reports.size());
      $display("end of test: mismatches");
      $finish;
   end

   // test sequence
   initial begin
      cfg_fold    = 1'b1;
      cfg_len     = 5'd1;
      cfg_pattern = '0;
      clear_text_state();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      feed_idles = 1'b1;
      sink_idles = 1'b1;
      test_case_folding();
      test_pattern_length();
      test_change_mid_text();
      test_position_saturation();
      test_random_text(1900);

      wait_quiet();
      if (match_reports.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d reports never arrived", $time, match_reports.size());
      end
      $display("covered %0d texts, %0d bytes, %0d result words (%0d found)",
               texts_sent, bytes_sent, reports_seen, found_seen);
      $display("random part ran %0d register settings; offset stop point exercised",
               phases_run);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
